[rtl/char_lcd_nibble_driver_assert.svh]
// Assertion macros used by the character LCD driver datapath.
// Depends on nothing; included inside module bodies.
`ifndef CHAR_LCD_NIBBLE_DRIVER_ASSERT_SVH
`define CHAR_LCD_NIBBLE_DRIVER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CLND_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("clnd assertion failed");

// Next-cycle implication, disabled during reset.
`define CLND_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("clnd assertion failed");

`endif

[rtl/clnd_pkg.sv]
// Shared types, codes and byte selection for the character LCD driver.
// Depends on nothing.
package clnd_pkg;

   typedef enum logic [2:0] {
      OP_INIT    = 3'd0,
      OP_COMMAND = 3'd1,
      OP_DATA    = 3'd2,
      OP_CHAR    = 3'd3,
      OP_GOTO    = 3'd4,
      OP_CLEAR   = 3'd5
   } op_type;

   localparam logic [1:0] CSR_EDGE_HOLD   = 2'd0;
   localparam logic [1:0] CSR_INIT_SETTLE = 2'd1;

   localparam logic [19:0] EDGE_HOLD_RESET   = 20'd16000;
   localparam logic [19:0] INIT_SETTLE_RESET = 20'd160000;

   localparam logic [7:0] LCD_RETURN_HOME  = 8'h02;
   localparam logic [7:0] LCD_FUNCTION_SET = 8'h28;
   localparam logic [7:0] LCD_CLEAR        = 8'h01;
   localparam logic [7:0] LCD_DISPLAY_ON   = 8'h0E;
   localparam logic [7:0] LCD_LINE1        = 8'h80;
   localparam logic [7:0] LCD_LINE2        = 8'hC0;
   localparam logic [7:0] LCD_UNDERSCORE   = 8'h5F;

   localparam logic [1:0] ROW_FIRST  = 2'd1;
   localparam logic [1:0] ROW_SECOND = 2'd2;

   typedef struct packed {
      logic       rs;
      logic [7:0] value;
   } lcd_byte_type;

   // Controller to datapath.
   typedef struct packed {
      logic load;
      logic emit;
      logic advance;
      logic tload_hold;
      logic tload_settle;
   } ctrl_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic empty;
      logic last;
      logic is_init;
      logic timer_done;
      logic out_busy;
   } dp_status_type;

   function automatic logic [7:0] init_byte(input logic [2:0] idx);
      logic [7:0] b;
      unique case (idx)
         3'd0:    b = LCD_RETURN_HOME;
         3'd1:    b = LCD_FUNCTION_SET;
         3'd2:    b = LCD_CLEAR;
         3'd3:    b = LCD_DISPLAY_ON;
         default: b = LCD_LINE1;
      endcase
      return b;
   endfunction

   // Number of bytes one item sends (zero for ignored items).
   function automatic logic [2:0] byte_count(input logic [2:0] op, input logic [1:0] row,
                                             input logic wrap);
      logic [2:0] n;
      unique case (op)
         OP_INIT:    n = 3'd5;
         OP_COMMAND: n = 3'd1;
         OP_DATA:    n = 3'd1;
         OP_CHAR:    n = wrap ? 3'd3 : 3'd1;
         OP_GOTO:    n = (row == ROW_FIRST || row == ROW_SECOND) ? 3'd1 : 3'd0;
         OP_CLEAR:   n = 3'd1;
         default:    n = 3'd0;
      endcase
      return n;
   endfunction

   // The byte at position idx of the item's sequence and its RS level.
   function automatic lcd_byte_type byte_select(input logic [2:0] op, input logic [7:0] bv,
                                                input logic [1:0] row, input logic [5:0] col,
                                                input logic [2:0] idx);
      lcd_byte_type r;
      logic [7:0]   base;
      base = (row == ROW_FIRST) ? LCD_LINE1 : LCD_LINE2;
      unique case (op)
         OP_INIT:    r = '{rs: 1'b0, value: init_byte(idx)};
         OP_COMMAND: r = '{rs: 1'b0, value: bv};
         OP_DATA:    r = '{rs: 1'b1, value: bv};
         OP_CHAR: begin
            unique case (idx)
               3'd0:    r = '{rs: 1'b1, value: bv};
               3'd1:    r = '{rs: 1'b1, value: LCD_UNDERSCORE};
               default: r = '{rs: 1'b0, value: LCD_LINE2};
            endcase
         end
         OP_GOTO:    r = '{rs: 1'b0, value: base + {2'b00, col} - 8'd1};
         default:    r = '{rs: 1'b0, value: LCD_CLEAR};
      endcase
      return r;
   endfunction

endpackage

[rtl/clnd_if.sv]
// Channel interfaces of the character LCD driver: request, response, register write.
// Depends on nothing.
interface clnd_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] op;
   logic [7:0] byte_value;
   logic [1:0] row_number;
   logic [5:0] column_number;
   modport source (output valid, op, byte_value, row_number, column_number, input ready);
   modport sink   (input valid, op, byte_value, row_number, column_number, output ready);
endinterface

interface clnd_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] bus_nibble;
   logic       reg_select;
   logic       enable_pin;
   logic       read_write;
   logic       settle_wait;
   logic       last_state;
   modport source (output valid, bus_nibble, reg_select, enable_pin, read_write,
                   settle_wait, last_state, input ready);
   modport sink   (input valid, bus_nibble, reg_select, enable_pin, read_write,
                   settle_wait, last_state, output ready);
endinterface

interface clnd_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [19:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[rtl/clnd_ctrl.sv]
// Sequencing state machine of the character LCD driver.
// Depends on clnd_pkg.
module clnd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  clnd_pkg::dp_status_type sts,
   output clnd_pkg::ctrl_cmd_type  cmd
);
   import clnd_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_PRESENT,
      ST_HOLD,
      ST_SETTLE
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;

   always_comb begin
      state_in = state_ff;
      ready_in = ready_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && ready_ff) begin
               cmd.load = 1'b1;
               state_in = ST_ISSUE;
               ready_in = 1'b0;
            end
         end
         ST_ISSUE: begin
            if (sts.empty) begin
               state_in = ST_IDLE;
               ready_in = 1'b1;
            end else begin
               cmd.emit = 1'b1;
               state_in = ST_PRESENT;
            end
         end
         ST_PRESENT: begin
            if (!sts.out_busy) begin
               cmd.tload_hold = 1'b1;
               state_in       = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (sts.timer_done) begin
               priority if (!sts.last) begin
                  cmd.advance = 1'b1;
                  state_in    = ST_ISSUE;
               end else if (sts.is_init) begin
                  cmd.tload_settle = 1'b1;
                  state_in         = ST_SETTLE;
               end else begin
                  state_in = ST_IDLE;
                  ready_in = 1'b1;
               end
            end
         end
         ST_SETTLE: begin
            if (sts.timer_done) begin
               state_in = ST_IDLE;
               ready_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
            ready_in = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

   assign req_ready = ready_ff;

endmodule

[rtl/clnd_dp.sv]
// Datapath of the character LCD driver: item latch, character count, step counter,
// hold timer, timing registers and the result register. Depends on clnd_pkg, clnd_if.
module clnd_dp #(
   parameter int WRAP_COUNT = 15
) (
   input  logic                    clock,
   input  logic                    reset,
   clnd_req_if.sink                req_chan,
   clnd_rsp_if.source              rsp_chan,
   clnd_csr_if.sink                csr_chan,
   input  clnd_pkg::ctrl_cmd_type  cmd,
   output clnd_pkg::dp_status_type sts
);
   import clnd_pkg::*;
   `include "char_lcd_nibble_driver_assert.svh"

   localparam logic [7:0] WRAP_VALUE = 8'(WRAP_COUNT);

   // Latched item.
   logic [2:0]  op_ff;
   logic [7:0]  bv_ff;
   logic [1:0]  row_ff;
   logic [5:0]  col_ff;
   logic [2:0]  nbytes_ff, nbytes_in;
   logic [7:0]  count_ff, count_in;
   logic [4:0]  step_ff, step_in;
   logic [19:0] timer_ff, timer_in;
   logic [19:0] edge_hold_ff, init_settle_ff;

   logic        out_valid_ff;
   logic [3:0]  out_nibble_ff;
   logic        out_rs_ff, out_en_ff, out_settle_ff, out_last_ff;

   logic [7:0]   count_inc;
   logic         wrap;
   logic [4:0]   total_states;
   logic         last;
   lcd_byte_type cur;

   assign count_inc    = count_ff + 8'd1;
   assign wrap         = (count_inc == WRAP_VALUE);
   assign total_states = {nbytes_ff, 2'b00};
   assign last         = (step_ff == total_states - 5'd1);
   assign cur          = byte_select(op_ff, bv_ff, row_ff, col_ff, step_ff[4:2]);

   always_comb begin
      count_in  = count_ff;
      nbytes_in = nbytes_ff;
      if (cmd.load) begin
         nbytes_in = byte_count(req_chan.op, req_chan.row_number,
                                (req_chan.op == OP_CHAR) && wrap);
         if (req_chan.op == OP_CHAR) begin
            count_in = count_inc;
         end else if (req_chan.op == OP_CLEAR) begin
            count_in = 8'd0;
         end
      end
      step_in = step_ff;
      if (cmd.load) begin
         step_in = 5'd0;
      end else if (cmd.advance) begin
         step_in = step_ff + 5'd1;
      end
      timer_in = timer_ff;
      priority if (cmd.tload_hold) begin
         timer_in = edge_hold_ff;
      end else if (cmd.tload_settle) begin
         timer_in = init_settle_ff;
      end else if (timer_ff != 20'd0) begin
         timer_in = timer_ff - 20'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff       <= 8'd0;
         step_ff        <= 5'd0;
         timer_ff       <= 20'd0;
         nbytes_ff      <= 3'd0;
         edge_hold_ff   <= EDGE_HOLD_RESET;
         init_settle_ff <= INIT_SETTLE_RESET;
         out_valid_ff   <= 1'b0;
      end else begin
         count_ff  <= count_in;
         step_ff   <= step_in;
         timer_ff  <= timer_in;
         nbytes_ff <= nbytes_in;
         if (csr_chan.valid) begin
            if (csr_chan.index == CSR_EDGE_HOLD) begin
               edge_hold_ff <= csr_chan.data;
            end else if (csr_chan.index == CSR_INIT_SETTLE) begin
               init_settle_ff <= csr_chan.data;
            end
         end
         if (cmd.emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_chan.op;
         bv_ff  <= req_chan.byte_value;
         row_ff <= req_chan.row_number;
         col_ff <= req_chan.column_number;
      end
      if (cmd.emit) begin
         out_nibble_ff <= step_ff[1] ? cur.value[3:0] : cur.value[7:4];
         out_rs_ff     <= cur.rs;
         out_en_ff     <= ~step_ff[0];
         out_settle_ff <= last && (op_ff == OP_INIT);
         out_last_ff   <= last;
      end
   end

   assign csr_chan.ready       = 1'b1;
   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.bus_nibble  = out_nibble_ff;
   assign rsp_chan.reg_select  = out_rs_ff;
   assign rsp_chan.enable_pin  = out_en_ff;
   assign rsp_chan.read_write  = 1'b0;
   assign rsp_chan.settle_wait = out_settle_ff;
   assign rsp_chan.last_state  = out_last_ff;

   assign sts.empty      = (nbytes_ff == 3'd0);
   assign sts.last       = last;
   assign sts.is_init    = (op_ff == OP_INIT);
   assign sts.timer_done = (timer_ff[19:1] == 19'd0);
   assign sts.out_busy   = out_valid_ff;

   `CLND_ASSERT_NOW(a_emit_into_free_reg, clock, reset, cmd.emit, !out_valid_ff)
   `CLND_ASSERT_NOW(a_step_in_range, clock, reset, out_valid_ff, step_ff < total_states)
   `CLND_ASSERT_NEXT(a_load_restarts_step, clock, reset, cmd.load, step_ff == 5'd0)
   `CLND_ASSERT_NOW(a_no_advance_past_last, clock, reset, cmd.advance, !last)

endmodule

[rtl/char_lcd_nibble_driver.sv]
// Channel   | Direction | Carries
// req_chan  | in        | op, byte_value, row_number, column_number
// rsp_chan  | out       | bus_nibble, reg_select, enable_pin, read_write, settle_wait, last_state
// csr_chan  | in        | register index (0 edge hold, 1 init settle) and 20-bit data
//
// Each byte sent gives four result items (enable high then low, for the high and
// then the low nibble). Each item is held in the result register until taken, and the
// hold timer then runs out the edge hold before the next one is produced; after the
// last state of init it also runs out the init settle. The hold timer paces the
// block; one item is in work at a time. Reset is synchronous and active high and
// restores the register defaults.
// A stalled response simply stretches the item; nothing is dropped.
// Depends on clnd_pkg, clnd_if, clnd_ctrl and clnd_dp.
module char_lcd_nibble_driver #(
   parameter int WRAP_COUNT = 15
) (
   input  logic       clock,
   input  logic       reset,
   clnd_req_if.sink   req_chan,
   clnd_rsp_if.source rsp_chan,
   clnd_csr_if.sink   csr_chan
);
   import clnd_pkg::*;

   // Commands from the state machine and status from the datapath.
   ctrl_cmd_type  cmd;
   dp_status_type sts;

   // The controller owns the request handshake; it is ready only while idle,
   // and it walks the pin states one at a time through the datapath.
   clnd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The datapath latches the item, updates the character count as the item is
   // accepted, selects each byte and nibble, and holds the result register.
   clnd_dp #(
      .WRAP_COUNT (WRAP_COUNT)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan),
      .cmd      (cmd),
      .sts      (sts)
   );

endmodule

[tb/tb_char_lcd_nibble_driver.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the 4-bit character LCD driver: directed and random requests,
// a scoreboard of predicted pin states, and register writes between phases.
// Depends on clnd_pkg, clnd_if and char_lcd_nibble_driver.
module tb_char_lcd_nibble_driver;
   import clnd_pkg::*;

   // The string wrap point; the block is built with the same value.
   localparam int CHAR_WRAP = 15;

   // Register indexes that decode to nothing. Writes there must leave the timing alone.
   localparam logic [1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [1:0] CSR_SPARE_HI = 2'd3;

   // Op codes beyond the package enum. The block ignores them.
   localparam logic [2:0] OP_SPARE_LO = 3'd6;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;

   localparam logic [19:0] HOLD_CEILING = 20'hFFFFF;
   localparam int          RUN_LIMIT_NS = 40_000_000;

   // One held pin state on the LCD bus, as the block reports it.
   typedef struct packed {
      logic [3:0] nibble;
      logic       rs;
      logic       en;
      logic       rw;
      logic       settle;
      logic       last;
   } pin_state_type;

   // One request waiting to be sent. When hold_off is set, the sender holds it back
   // until every pin state that was predicted so far has arrived.
   typedef struct packed {
      logic [2:0] op;
      logic [7:0] byte_value;
      logic [1:0] row;
      logic [5:0] column;
      logic       hold_off;
   } lcd_request_type;

   typedef enum int {
      SINK_FREE,
      SINK_CHOPPY,
      SINK_BURSTY
   } sink_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   clnd_req_if req_bus ();
   clnd_rsp_if rsp_bus ();
   clnd_csr_if csr_bus ();

   char_lcd_nibble_driver #(
      .WRAP_COUNT (CHAR_WRAP)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Requests still to be sent, and the pin states the block still owes.
   lcd_request_type pending_requests[$];
   pin_state_type   pin_states_due[$];

   // The predictor's copy of the block's running state.
   logic [7:0]  char_count = 8'd0;
   // Shadow copies of the timing registers. They only size the idle waits.
   logic [19:0] edge_hold_now   = EDGE_HOLD_RESET;
   logic [19:0] init_settle_now = INIT_SETTLE_RESET;

   int requests_in_flight = 0;
   bit req_accepted       = 1'b0;
   int failures           = 0;
   int requests_accepted  = 0;
   int quiet_requests     = 0;
   int states_checked     = 0;
   int line_wraps         = 0;
   int register_writes    = 0;

   int            burst_left = 1;
   int            gap_left   = 0;
   sink_mode_type sink_mode  = SINK_FREE;
   int            sink_left  = 0;
   int            stall_left = 0;

   task automatic note_failure(input string msg);
      failures++;
      $display("%0t ns: %s", $time, msg);
   endtask

   // One byte on the bus is four held states: the high nibble with enable high and then
   // low, then the same for the low nibble.
   task automatic queue_byte(input logic [7:0] b, input logic rs);
      pin_state_type s;
      s        = '0;
      s.rs     = rs;
      s.nibble = b[7:4];
      s.en     = 1'b1;
      pin_states_due.push_back(s);
      s.en     = 1'b0;
      pin_states_due.push_back(s);
      s.nibble = b[3:0];
      s.en     = 1'b1;
      pin_states_due.push_back(s);
      s.en     = 1'b0;
      pin_states_due.push_back(s);
   endtask

   // Works out the pin states that one accepted request must cause and appends them to
   // the scoreboard. The character count is kept here, as the block keeps it.
   task automatic predict_pin_states(input logic [2:0] op, input logic [7:0] bv,
                                     input logic [1:0] row, input logic [5:0] col);
      int            first;
      pin_state_type tail;
      first = pin_states_due.size();
      unique case (op)
         OP_INIT: begin
            queue_byte(LCD_RETURN_HOME, 1'b0);
            queue_byte(LCD_FUNCTION_SET, 1'b0);
            queue_byte(LCD_CLEAR, 1'b0);
            queue_byte(LCD_DISPLAY_ON, 1'b0);
            queue_byte(LCD_LINE1, 1'b0);
         end
         OP_COMMAND: queue_byte(bv, 1'b0);
         OP_DATA:    queue_byte(bv, 1'b1);
         OP_CHAR: begin
            queue_byte(bv, 1'b1);
            char_count = char_count + 8'd1;
            // Reaching the wrap count moves the cursor to the second line. The count
            // itself runs on and only wraps at eight bits.
            if (char_count == CHAR_WRAP) begin
               queue_byte(LCD_UNDERSCORE, 1'b1);
               queue_byte(LCD_LINE2, 1'b0);
               line_wraps++;
            end
         end
         OP_GOTO: begin
            // Columns count from one; column zero wraps below the line base.
            if (row == ROW_FIRST)
               queue_byte(LCD_LINE1 + {2'b00, col} - 8'd1, 1'b0);
            else if (row == ROW_SECOND)
               queue_byte(LCD_LINE2 + {2'b00, col} - 8'd1, 1'b0);
         end
         OP_CLEAR: begin
            queue_byte(LCD_CLEAR, 1'b0);
            char_count = 8'd0;
         end
         default: ;
      endcase
      if (pin_states_due.size() > first) begin
         tail      = pin_states_due[pin_states_due.size() - 1];
         tail.last = 1'b1;
         if (op == OP_INIT)
            tail.settle = 1'b1;
         pin_states_due[pin_states_due.size() - 1] = tail;
      end else begin
         quiet_requests++;
      end
   endtask

   function automatic bit produces_pin_states(input logic [2:0] op, input logic [1:0] row);
      if (op == OP_GOTO)
         return row == ROW_FIRST || row == ROW_SECOND;
      return op <= OP_CLEAR;
   endfunction

   task automatic queue_request(input logic [2:0] op, input logic [7:0] bv,
                                input logic [1:0] row, input logic [5:0] col,
                                input logic hold_off);
      lcd_request_type r;
      r.op         = op;
      r.byte_value = bv;
      r.row        = row;
      r.column     = col;
      r.hold_off   = hold_off;
      pending_requests.push_back(r);
   endtask

   // Mostly well-formed text: a clear or a cursor move followed by a run of counted
   // characters. The rest is init, raw bytes, and noise that includes ignored requests.
   task automatic queue_random_traffic(input int target);
      int   active;
      int   kind;
      int   chars;
      logic hold_off;
      active = 0;
      while (active < target) begin
         kind     = $urandom_range(0, 99);
         hold_off = ($urandom_range(0, 9) == 0);
         if (kind < 55) begin
            if ($urandom_range(0, 2) == 0)
               queue_request(OP_CLEAR, 8'($urandom_range(0, 255)),
                             2'($urandom_range(0, 3)), 6'($urandom_range(0, 63)),
                             hold_off);
            else
               queue_request(OP_GOTO, 8'($urandom_range(0, 255)),
                             $urandom_range(0, 1) ? ROW_SECOND : ROW_FIRST,
                             6'($urandom_range(0, 63)), hold_off);
            chars = $urandom_range(1, 20);
            repeat (chars)
               queue_request(OP_CHAR, 8'($urandom_range(0, 255)),
                             2'($urandom_range(0, 3)), 6'($urandom_range(0, 63)), 1'b0);
            active += chars + 1;
         end else if (kind < 63) begin
            queue_request(OP_INIT, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
                          6'($urandom_range(0, 63)), hold_off);
            active++;
         end else if (kind < 80) begin
            queue_request($urandom_range(0, 1) ? OP_DATA : OP_COMMAND,
                          8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
                          6'($urandom_range(0, 63)), hold_off);
            active++;
         end else begin
            lcd_request_type junk;
            junk = lcd_request_type'($urandom);
            queue_request(junk.op, junk.byte_value, junk.row, junk.column, hold_off);
            if (produces_pin_states(junk.op, junk.row))
               active++;
         end
      end
   endtask

   task automatic write_register(input logic [1:0] idx, input logic [19:0] value);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do
         @(posedge clock);
      while (!csr_bus.ready);
      register_writes++;
      if (idx == CSR_EDGE_HOLD)
         edge_hold_now = value;
      else if (idx == CSR_INIT_SETTLE)
         init_settle_now = value;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // Waits until every queued request is taken and every predicted state has come, then
   // lets the hold timer and any settle wait run out. Requests that cause no pin state
   // may leave the block busy after the last result, so the wait is not skipped.
   task automatic finish_phase();
      while (pending_requests.size() != 0 || requests_in_flight != 0 ||
             pin_states_due.size() != 0)
         @(negedge clock);
      repeat (int'(edge_hold_now) + int'(init_settle_now) + 16)
         @(posedge clock);
   endtask

   // Request sender. Inputs change on the falling edge. An offered request is held
   // until the rising edge that takes it; between bursts the valid line may drop for a
   // random number of cycles, and a request marked hold_off waits for the scoreboard
   // to empty.
   always @(negedge clock) begin : request_driver
      lcd_request_type next_req;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (req_bus.valid && !req_accepted) begin
         // Still waiting for the block to take the current request.
      end else begin
         req_accepted = 1'b0;
         if (gap_left != 0) begin
            gap_left--;
            req_bus.valid <= 1'b0;
         end else if (pending_requests.size() == 0 ||
                      (pending_requests[0].hold_off && pin_states_due.size() != 0)) begin
            req_bus.valid <= 1'b0;
         end else begin
            next_req = pending_requests.pop_front();
            requests_in_flight++;
            req_bus.valid         <= 1'b1;
            req_bus.op            <= next_req.op;
            req_bus.byte_value    <= next_req.byte_value;
            req_bus.row_number    <= next_req.row;
            req_bus.column_number <= next_req.column;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 8);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
         end
      end
   end

   // Response ready follows a pattern picked at random for each span: always ready,
   // ready at random, or mostly ready with stalls of random length.
   always @(negedge clock) begin : response_sink
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (sink_left == 0) begin
            sink_mode = sink_mode_type'($urandom_range(0, 2));
            sink_left = $urandom_range(20, 120);
         end else begin
            sink_left--;
         end
         unique case (sink_mode)
            SINK_FREE:   rsp_bus.ready <= 1'b1;
            SINK_CHOPPY: rsp_bus.ready <= ($urandom_range(0, 2) != 0);
            default: begin
               if (stall_left != 0) begin
                  stall_left--;
                  rsp_bus.ready <= 1'b0;
               end else if ($urandom_range(0, 5) == 0) begin
                  stall_left = $urandom_range(1, 12);
                  rsp_bus.ready <= 1'b0;
               end else begin
                  rsp_bus.ready <= 1'b1;
               end
            end
         endcase
      end
   end

   // Sampling at the rising edge. Each pin state taken is checked against the oldest
   // prediction, and each request taken is run through the predictor.
   always @(posedge clock) begin : pin_state_monitor
      pin_state_type seen;
      pin_state_type wanted;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen.nibble = rsp_bus.bus_nibble;
            seen.rs     = rsp_bus.reg_select;
            seen.en     = rsp_bus.enable_pin;
            seen.rw     = rsp_bus.read_write;
            seen.settle = rsp_bus.settle_wait;
            seen.last   = rsp_bus.last_state;
            if (pin_states_due.size() == 0) begin
               note_failure($sformatf("pin state with none expected: expected nothing, actual %h",
                                      seen));
            end else begin
               wanted = pin_states_due.pop_front();
               states_checked++;
               if (seen.nibble !== wanted.nibble || seen.rs !== wanted.rs ||
                   seen.en !== wanted.en || seen.rw !== wanted.rw ||
                   seen.settle !== wanted.settle || seen.last !== wanted.last)
                  note_failure($sformatf({"pin state mismatch: expected nib=%h rs=%b en=%b ",
                                          "rw=%b settle=%b last=%b, actual nib=%h rs=%b ",
                                          "en=%b rw=%b settle=%b last=%b"},
                     wanted.nibble, wanted.rs, wanted.en, wanted.rw, wanted.settle,
                     wanted.last, seen.nibble, seen.rs, seen.en, seen.rw, seen.settle,
                     seen.last));
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            req_accepted = 1'b1;
            requests_in_flight--;
            requests_accepted++;
            predict_pin_states(req_bus.op, req_bus.byte_value, req_bus.row_number,
                               req_bus.column_number);
         end
      end
   end

   initial begin : stimulus
      req_bus.valid         = 1'b0;
      req_bus.op            = OP_INIT;
      req_bus.byte_value    = 8'd0;
      req_bus.row_number    = 2'd0;
      req_bus.column_number = 6'd0;
      rsp_bus.ready         = 1'b0;
      csr_bus.valid         = 1'b0;
      csr_bus.index         = CSR_EDGE_HOLD;
      csr_bus.data          = 20'd0;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // One raw command on the reset timing, so the default hold is exercised once.
      queue_request(OP_COMMAND, LCD_DISPLAY_ON, 2'd0, 6'd0, 1'b0);
      finish_phase();

      // Both registers go to their ceiling and straight back down, with no request in
      // between; a full-length hold would take far too long to run.
      write_register(CSR_EDGE_HOLD, HOLD_CEILING);
      write_register(CSR_INIT_SETTLE, HOLD_CEILING);
      write_register(CSR_EDGE_HOLD, 20'd3);
      write_register(CSR_INIT_SETTLE, 20'd5);

      // Directed part: every operation, byte extremes, column zero and the top column
      // on both rows, rows that do nothing, and the unused op codes.
      queue_request(OP_INIT, 8'h00, 2'd0, 6'd0, 1'b0);
      queue_request(OP_COMMAND, 8'h00, 2'd0, 6'd0, 1'b0);
      queue_request(OP_COMMAND, 8'hFF, 2'd3, 6'd63, 1'b0);
      queue_request(OP_DATA, 8'h00, 2'd0, 6'd0, 1'b0);
      queue_request(OP_DATA, 8'hFF, 2'd3, 6'd63, 1'b0);
      queue_request(OP_CHAR, 8'h00, 2'd0, 6'd0, 1'b0);
      queue_request(OP_CHAR, 8'hFF, 2'd3, 6'd63, 1'b0);
      queue_request(OP_GOTO, 8'h00, ROW_FIRST, 6'd0, 1'b0);
      queue_request(OP_GOTO, 8'h00, ROW_FIRST, 6'd1, 1'b0);
      queue_request(OP_GOTO, 8'hFF, ROW_FIRST, 6'd63, 1'b0);
      queue_request(OP_GOTO, 8'h00, ROW_SECOND, 6'd0, 1'b0);
      queue_request(OP_GOTO, 8'h00, ROW_SECOND, 6'd1, 1'b0);
      queue_request(OP_GOTO, 8'hFF, ROW_SECOND, 6'd63, 1'b0);
      queue_request(OP_GOTO, 8'hFF, 2'd0, 6'd5, 1'b0);
      queue_request(OP_GOTO, 8'hFF, 2'd3, 6'd63, 1'b0);
      queue_request(OP_SPARE_LO, 8'hFF, 2'd3, 6'd63, 1'b0);
      queue_request(OP_SPARE_HI, 8'h00, 2'd0, 6'd0, 1'b0);
      // The sender holds this one back until the block has produced everything so far.
      queue_request(OP_CLEAR, 8'h00, 2'd0, 6'd0, 1'b1);
      queue_request(OP_CHAR, 8'h41, 2'd1, 6'd1, 1'b0);
      finish_phase();

      // Shortest timing. After a clear, one string runs past the wrap count, so the
      // underscore and the second-line command appear once and the count runs on.
      write_register(CSR_EDGE_HOLD, 20'd1);
      write_register(CSR_INIT_SETTLE, 20'd1);
      queue_request(OP_CLEAR, 8'h00, 2'd0, 6'd0, 1'b0);
      repeat (20)
         queue_request(OP_CHAR, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
                       6'($urandom_range(0, 63)), 1'b0);
      finish_phase();

      // Writes to indexes that decode to nothing must not slow the block down.
      write_register(CSR_SPARE_LO, 20'($urandom_range(0, 20'hFFFFF)));
      write_register(CSR_SPARE_HI, HOLD_CEILING);

      // Random part in four timing settings.
      for (int phase = 0; phase < 4; phase++) begin
         write_register(CSR_EDGE_HOLD, (phase == 0) ? 20'd1 : 20'($urandom_range(1, 8)));
         write_register(CSR_INIT_SETTLE,
                        (phase == 0) ? 20'd1 : 20'($urandom_range(1, 60)));
         queue_random_traffic(12);
         finish_phase();
      end

      $display("Covered %0d requests (%0d with no pin activity), %0d pin states checked.",
               requests_accepted, quiet_requests, states_checked);
      $display("Register writes: %0d; second-line wraps predicted: %0d.",
               register_writes, line_wraps);
      if (failures == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin : watchdog
      #(RUN_LIMIT_NS);
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
